FILE: src/bdl_pkg.sv
package bdl_pkg;

    // Block sizes
    localparam int NUM_BUTTONS = 9;
    localparam int QUEUE_DEPTH = 16;
    localparam int BTN_IDX_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    // Register reset values
    localparam logic [9:0] DEBOUNCE_RESET    = 10'd20;
    localparam logic [9:0] SCAN_PERIOD_RESET = 10'd1;
    localparam logic [3:0] LOCK_BUTTON_RESET = 4'd8;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_DEBOUNCE_TIME = 2'd0,
        REG_SCAN_PERIOD   = 2'd1,
        REG_LOCK_BUTTON   = 2'd2
    } reg_idx_t;

    // Item operations
    typedef enum logic [1:0] {
        OP_SCAN = 2'd0,
        OP_POLL = 2'd1,
        OP_INIT = 2'd2
    } op_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WALK,
        ST_EMIT
    } state_t;

    // One queued event
    typedef struct packed {
        logic [3:0] button;
        logic       pressed;
    } event_t;

    // Command broadcast to every button lane
    typedef struct packed {
        logic        step;
        logic        init;
        logic [31:0] now;
        logic [9:0]  debounce;
    } lane_cmd_t;

endpackage

FILE: src/bdl_lane.sv
module bdl_lane (
    input  logic                aclk,
    input  logic                aresetn,
    input  bdl_pkg::lane_cmd_t  cmd,
    input  logic                pin_level,
    output logic                stable_level,
    output logic                level_accepted
);

    logic        raw_reg, raw_next;
    logic        stable_reg, stable_next;
    logic [31:0] change_time_reg, change_time_next;
    logic        accept_reg, accept_next;

    logic        pressed;
    logic        changed;
    logic [31:0] held;
    logic        held_ok;

    // Track the raw level and decide whether it has held long enough
    always_comb begin
        pressed          = ~pin_level;
        changed          = (pressed != raw_reg);
        held             = cmd.now - change_time_reg;
        held_ok          = changed ? (cmd.debounce == 10'd0) : (held >= 32'(cmd.debounce));
        raw_next         = raw_reg;
        stable_next      = stable_reg;
        change_time_next = change_time_reg;
        accept_next      = accept_reg;
        if (cmd.init) begin
            raw_next         = pressed;
            stable_next      = pressed;
            change_time_next = cmd.now;
            accept_next      = 1'b0;
        end else if (cmd.step) begin
            if (changed) begin
                raw_next         = pressed;
                change_time_next = cmd.now;
            end
            accept_next = (pressed != stable_reg) && held_ok;
            if (accept_next) begin
                stable_next = pressed;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_reg         <= 1'b0;
            stable_reg      <= 1'b0;
            change_time_reg <= 32'd0;
            accept_reg      <= 1'b0;
        end else begin
            raw_reg         <= raw_next;
            stable_reg      <= stable_next;
            change_time_reg <= change_time_next;
            accept_reg      <= accept_next;
        end
    end

    assign stable_level   = stable_reg;
    assign level_accepted = accept_reg;

endmodule

FILE: src/bdl_fifo.sv
module bdl_fifo (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        clear,
    input  logic                        push,
    input  bdl_pkg::event_t             push_data,
    input  logic                        pop,
    output bdl_pkg::event_t             pop_data,
    output logic                        full,
    output logic                        empty,
    output logic [bdl_pkg::PTR_W-1:0]   count
);

    localparam logic [bdl_pkg::PTR_W-1:0] LAST_SLOT = bdl_pkg::PTR_W'(bdl_pkg::QUEUE_DEPTH - 1);

    bdl_pkg::event_t mem [bdl_pkg::QUEUE_DEPTH];
    bdl_pkg::event_t pop_data_reg;

    logic [bdl_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [bdl_pkg::PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [bdl_pkg::PTR_W-1:0] wr_inc, rd_inc;

    // Advance pointers around the ring
    always_comb begin
        wr_inc      = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        rd_inc      = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        full        = (wr_inc == rd_ptr_reg);
        empty       = (wr_ptr_reg == rd_ptr_reg);
        count       = (wr_ptr_reg >= rd_ptr_reg) ? (wr_ptr_reg - rd_ptr_reg)
                    : bdl_pkg::PTR_W'(bdl_pkg::QUEUE_DEPTH + int'(wr_ptr_reg) - int'(rd_ptr_reg));
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (clear) begin
            wr_ptr_next = '0;
            rd_ptr_next = '0;
        end else begin
            if (push && !full) begin
                wr_ptr_next = wr_inc;
            end
            if (pop && !empty) begin
                rd_ptr_next = rd_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Event storage, registered read
    always_ff @(posedge aclk) begin
        if (push && !full && !clear) begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (pop) begin
            pop_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign pop_data = pop_data_reg;

    a_no_wrap_on_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !empty && !push && !clear) |=> (count == $past(count) - 1'b1))
        else $error("fifo count did not drop after a pop");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        clear |=> empty)
        else $error("fifo not empty after clear");

    a_full_blocks_push: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && full && !pop && !clear) |=> (wr_ptr_reg == $past(wr_ptr_reg)))
        else $error("fifo accepted a push while full");

endmodule

FILE: src/button_debounce_lock_event_queue.sv
// Sequence: a due scan passes through an evaluation state, a merge state per button (to apply
// lock logic and enqueue in order) and an output state; poll, initialize and skipped scans
// pass through evaluation and output only. The output state waits while a result is unaccepted.
// Throughput: one item at a time; a new item is accepted only after the last result is loaded.
// Reset: aresetn synchronous, active low; clears button state, flags, queue pointers and
// restores register defaults. Queue contents are not cleared.
module button_debounce_lock_event_queue (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] now_time, [40:32] pin_levels, [47:41] zero
    input  logic [1:0]  s_tuser,   // [1:0] op
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] event_button, [4] event_pressed,
                                   // [5] screen_locked, [6] backlight_on,
                                   // [7] quarantine_active, [11:8] queue_count,
                                   // [15:12] dropped_count
    output logic [0:0]  m_tuser,   // [0] event_valid
    // Configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    localparam int NB = bdl_pkg::NUM_BUTTONS;
    localparam int IW = bdl_pkg::BTN_IDX_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(NB - 1);

    bdl_pkg::state_t state_reg, state_next;

    logic [9:0]  debounce_reg;
    logic [9:0]  scan_period_reg;
    logic [3:0]  lock_button_reg;

    bdl_pkg::op_t op_reg;
    logic [31:0]  now_reg;
    logic [NB-1:0] pins_reg;

    logic [31:0]  last_scan_reg, last_scan_next;
    logic         lock_reg, lock_next;
    logic         quar_reg, quar_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [3:0]   dropped_reg, dropped_next;
    logic         hit_reg, hit_next;

    logic         m_tvalid_reg;
    logic [15:0]  m_tdata_reg;
    logic         m_tuser_reg;
    logic         out_load;

    bdl_pkg::lane_cmd_t lane_cmd;
    logic [NB-1:0] lane_stable;
    logic [NB-1:0] lane_accept;

    logic            fifo_clear, fifo_push, fifo_pop;
    bdl_pkg::event_t fifo_push_data, fifo_pop_data;
    logic            fifo_full, fifo_empty;
    logic [bdl_pkg::PTR_W-1:0] fifo_count;

    logic         in_accept;
    logic         scan_due;
    logic         others_pressed;
    logic         walk_accept, walk_level, walk_is_lock, walk_suppress;
    logic         lk, qr;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == bdl_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg    <= bdl_pkg::DEBOUNCE_RESET;
            scan_period_reg <= bdl_pkg::SCAN_PERIOD_RESET;
            lock_button_reg <= bdl_pkg::LOCK_BUTTON_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (bdl_pkg::reg_idx_t'(cfg_index))
                bdl_pkg::REG_DEBOUNCE_TIME: debounce_reg    <= cfg_data;
                bdl_pkg::REG_SCAN_PERIOD:   scan_period_reg <= cfg_data;
                bdl_pkg::REG_LOCK_BUTTON:   lock_button_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Capture the accepted item
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            op_reg   <= bdl_pkg::op_t'(s_tuser);
            now_reg  <= s_tdata[31:0];
            pins_reg <= s_tdata[32 +: NB];
        end
    end

    // Button lanes
    genvar g;
    generate
        for (g = 0; g < NB; g++) begin : g_lane
            bdl_lane u_lane (
                .aclk           (aclk),
                .aresetn        (aresetn),
                .cmd            (lane_cmd),
                .pin_level      (pins_reg[g]),
                .stable_level   (lane_stable[g]),
                .level_accepted (lane_accept[g])
            );
        end
    endgenerate

    // Event ring
    bdl_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (fifo_clear),
        .push      (fifo_push),
        .push_data (fifo_push_data),
        .pop       (fifo_pop),
        .pop_data  (fifo_pop_data),
        .full      (fifo_full),
        .empty     (fifo_empty),
        .count     (fifo_count)
    );

    // Any non-lock button still stably pressed
    always_comb begin
        others_pressed = 1'b0;
        for (int i = 0; i < NB; i++) begin
            if ((4'(i) != lock_button_reg) && lane_stable[i]) begin
                others_pressed = 1'b1;
            end
        end
    end

    // Sequencer: evaluate lanes, merge their findings in button order, emit the result
    always_comb begin
        state_next     = state_reg;
        last_scan_next = last_scan_reg;
        lock_next      = lock_reg;
        quar_next      = quar_reg;
        idx_next       = idx_reg;
        dropped_next   = dropped_reg;
        hit_next       = hit_reg;
        out_load       = 1'b0;
        lane_cmd.step     = 1'b0;
        lane_cmd.init     = 1'b0;
        lane_cmd.now      = now_reg;
        lane_cmd.debounce = debounce_reg;
        fifo_clear     = 1'b0;
        fifo_push      = 1'b0;
        fifo_pop       = 1'b0;
        scan_due       = (now_reg - last_scan_reg) >= 32'(scan_period_reg);
        walk_accept    = lane_accept[idx_reg];
        walk_level     = lane_stable[idx_reg];
        walk_is_lock   = (4'(idx_reg) == lock_button_reg);
        lk             = lock_reg;
        qr             = quar_reg;
        walk_suppress  = 1'b0;
        fifo_push_data.button  = 4'(idx_reg);
        fifo_push_data.pressed = walk_level;

        case (state_reg)
            bdl_pkg::ST_IDLE: begin
                if (in_accept) begin
                    state_next = bdl_pkg::ST_EVAL;
                end
            end
            bdl_pkg::ST_EVAL: begin
                dropped_next = 4'd0;
                hit_next     = 1'b0;
                idx_next     = '0;
                state_next   = bdl_pkg::ST_EMIT;
                case (op_reg)
                    bdl_pkg::OP_SCAN: begin
                        if (scan_due) begin
                            lane_cmd.step  = 1'b1;
                            last_scan_next = now_reg;
                            state_next     = bdl_pkg::ST_WALK;
                        end
                    end
                    bdl_pkg::OP_POLL: begin
                        fifo_pop = !fifo_empty;
                        hit_next = !fifo_empty;
                    end
                    bdl_pkg::OP_INIT: begin
                        lane_cmd.init  = 1'b1;
                        last_scan_next = now_reg;
                        fifo_clear     = 1'b1;
                        lock_next      = 1'b0;
                        quar_next      = 1'b0;
                    end
                    default: ;
                endcase
            end
            bdl_pkg::ST_WALK: begin
                // Apply one button's new stable level
                if (walk_accept) begin
                    if (walk_is_lock && walk_level) begin
                        lk = !lk;
                        if (!lk) begin
                            qr = 1'b1;
                        end
                    end
                    walk_suppress = !walk_is_lock && (lk || qr);
                    if (!walk_suppress) begin
                        if (fifo_full) begin
                            dropped_next = dropped_reg + 4'd1;
                        end else begin
                            fifo_push = 1'b1;
                        end
                    end
                end
                if (idx_reg == LAST_IDX) begin
                    if (qr && !others_pressed) begin
                        qr = 1'b0;
                    end
                    state_next = bdl_pkg::ST_EMIT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
                lock_next = lk;
                quar_next = qr;
            end
            bdl_pkg::ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = bdl_pkg::ST_IDLE;
                end
            end
            default: state_next = bdl_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= bdl_pkg::ST_IDLE;
            last_scan_reg <= 32'd0;
            lock_reg      <= 1'b0;
            quar_reg      <= 1'b0;
            idx_reg       <= '0;
            dropped_reg   <= 4'd0;
            hit_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            last_scan_reg <= last_scan_next;
            lock_reg      <= lock_next;
            quar_reg      <= quar_next;
            idx_reg       <= idx_next;
            dropped_reg   <= dropped_next;
            hit_reg       <= hit_next;
        end
    end

    // Output register: hold until the transaction completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tuser_reg <= hit_reg;
            m_tdata_reg <= {dropped_reg,
                            4'(fifo_count),
                            quar_reg,
                            !lock_reg,
                            lock_reg,
                            hit_reg ? fifo_pop_data.pressed : 1'b0,
                            hit_reg ? fifo_pop_data.button : 4'd0};
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    a_init_clears_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bdl_pkg::ST_EMIT && op_reg == bdl_pkg::OP_INIT) |-> (!lock_reg && !quar_reg))
        else $error("initialize left lock or quarantine set");

    a_drop_only_on_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bdl_pkg::ST_EMIT && op_reg != bdl_pkg::OP_SCAN) |-> (dropped_reg == 4'd0))
        else $error("dropped count nonzero outside a scan");

    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == bdl_pkg::ST_WALK) |-> (int'(idx_reg) < NB))
        else $error("merge index past last button");

    a_hit_only_on_poll: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && hit_reg) |-> (op_reg == bdl_pkg::OP_POLL))
        else $error("event reported for an item that is not a poll");

endmodule
